### hw/rtl/alr_pkg.sv
`timescale 1ns / 1ps

package alr_pkg;

  // Store geometry and sample format.
  localparam int LOOP_DEPTH = 65536;
  localparam int SAMPLE_W   = 24;
  localparam int ADDR_W     = $clog2(LOOP_DEPTH);
  localparam int CNT_W      = ADDR_W + 1;
  localparam int CFG_W      = 17;
  localparam int OP_W       = 3;
  localparam int MODE_W     = 2;
  localparam int ACC_W      = SAMPLE_W + 2;

  // Stream payload widths, padded to whole bytes.
  localparam int IN_DATA_W  = ((2 * SAMPLE_W + MODE_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((2 * SAMPLE_W + 7) / 8) * 8;

  localparam logic [OP_W-1:0] OP_SAMPLE = 3'd0;
  localparam logic [OP_W-1:0] OP_MODE   = 3'd1;
  localparam logic [OP_W-1:0] OP_STORE  = 3'd2;
  localparam logic [OP_W-1:0] OP_CLRT   = 3'd3;
  localparam logic [OP_W-1:0] OP_CLRA   = 3'd4;

  localparam logic [MODE_W-1:0] MODE_STOP   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RECORD = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PLAY   = 2'd2;

  localparam logic signed [ACC_W-1:0] ACC_SMAX =
    ACC_W'((64'sd1 <<< (SAMPLE_W - 1)) - 64'sd1);
  localparam logic signed [ACC_W-1:0] ACC_SMIN = ~ACC_SMAX;

  typedef logic signed [ACC_W-1:0] acc_t;

  // One stereo frame; left sits in the low bits.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] r;
    logic signed [SAMPLE_W-1:0] l;
  } frame_t;

  typedef struct packed {
    acc_t r;
    acc_t l;
  } acc_pair_t;

  function automatic acc_t sext_acc(input logic [SAMPLE_W-1:0] x);
    return {{(ACC_W - SAMPLE_W){x[SAMPLE_W-1]}}, x};
  endfunction

endpackage

### hw/rtl/alr_ram.sv
`timescale 1ns / 1ps

module alr_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/alr_sat_add.sv
`timescale 1ns / 1ps

// Shared two-lane adder with saturation to the sample range.
module alr_sat_add (
  input  alr_pkg::acc_pair_t a_i,
  input  alr_pkg::acc_pair_t b_i,
  output alr_pkg::acc_pair_t sum_o,
  output alr_pkg::frame_t    sat_o
);
  import alr_pkg::*;

  acc_pair_t sum;

  always_comb begin
    sum.l = a_i.l + b_i.l;
    sum.r = a_i.r + b_i.r;
    if (sum.l > ACC_SMAX) begin
      sat_o.l = ACC_SMAX[SAMPLE_W-1:0];
    end else if (sum.l < ACC_SMIN) begin
      sat_o.l = ACC_SMIN[SAMPLE_W-1:0];
    end else begin
      sat_o.l = sum.l[SAMPLE_W-1:0];
    end
    if (sum.r > ACC_SMAX) begin
      sat_o.r = ACC_SMAX[SAMPLE_W-1:0];
    end else if (sum.r < ACC_SMIN) begin
      sat_o.r = ACC_SMIN[SAMPLE_W-1:0];
    end else begin
      sat_o.r = sum.r[SAMPLE_W-1:0];
    end
  end

  assign sum_o = sum;

endmodule

### hw/rtl/audio_loop_recorder.sv
`timescale 1ns / 1ps

// Stereo loop recorder with overdub on 24-bit signed samples.
// Input beats arrive on the s_axis channel: tuser carries the operation (sample, mode request,
// store take, clear take, clear all) and tdata the two samples and the requested mode. Every
// input beat yields exactly one output beat on m_axis: the mixed, saturated samples in tdata
// and a reject flag in tuser. The loop capacity register is to be written through cfg_we_i
// only while the block is idle; the block itself does not enforce this.
// Steps from the accepting edge: a sample in stop or in the first take, a mode request and an
// unused code finish in S_DISP; an overdub or play sample goes on through S_ADD1 and S_ADD2,
// set by the registered read of the take and layer RAMs followed by two passes through the
// shared saturating adder. Store take walks S_WRD then S_WWR for every frame up to the capacity
// (read then write of every frame on the shared RAM address); clear take and clear all write
// every frame up to the capacity in S_WCLR. The result beat turns valid in the same cycle
// that s_axis_tready rises again.
// After reset the block runs a clearing pass over all 65536 frames of both stores, one frame
// per cycle, during which s_axis_tready stays low.
// The result sits in an output register, so a new beat is accepted while the previous
// result waits on a stalled receiver; the block only holds its work when a second result is
// ready and the output register is still full.
module audio_loop_recorder (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration: loop capacity in stereo frames.
  input  logic                                cfg_we_i,
  input  logic [alr_pkg::CFG_W-1:0]           cfg_wdata_i,
  // Input stream.
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata from bit 0 up: sample_left[23:0], sample_right[47:24], requested_mode[49:48], zero pad.
  input  logic [alr_pkg::IN_DATA_W-1:0]       s_axis_tdata,
  // tuser: op[2:0].
  input  logic [alr_pkg::OP_W-1:0]            s_axis_tuser,
  // Output stream.
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // tdata from bit 0 up: out_left[23:0], out_right[47:24].
  output logic [alr_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  // tuser: status[0], set when a mode request was rejected.
  output logic                                m_axis_tuser
);
  import alr_pkg::*;

  localparam int ST_W = 4;
  localparam logic [ST_W-1:0] S_INIT = 4'd0;
  localparam logic [ST_W-1:0] S_IDLE = 4'd1;
  localparam logic [ST_W-1:0] S_DISP = 4'd2;
  localparam logic [ST_W-1:0] S_ADD1 = 4'd3;
  localparam logic [ST_W-1:0] S_ADD2 = 4'd4;
  localparam logic [ST_W-1:0] S_WRD  = 4'd5;
  localparam logic [ST_W-1:0] S_WWR  = 4'd6;
  localparam logic [ST_W-1:0] S_WCLR = 4'd7;
  localparam logic [ST_W-1:0] S_OUT  = 4'd8;

  localparam logic [CNT_W-1:0] DEPTH_LAST = CNT_W'(LOOP_DEPTH - 1);
  localparam logic [CFG_W-1:0] CAP_RESET  = CFG_W'(LOOP_DEPTH);

  // Control state.
  logic [ST_W-1:0]   state_q, state_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic [CNT_W-1:0]  pos_q, pos_d;
  logic [CNT_W-1:0]  len_q, len_d;
  logic [MODE_W-1:0] mode_q, mode_d;
  logic              first_q, first_d;
  logic [CFG_W-1:0]  cap_q;
  logic              m_valid_q, m_valid_d;

  // Payload registers.
  logic [OP_W-1:0]   op_q;
  frame_t            in_q;
  logic [MODE_W-1:0] req_q;
  acc_pair_t         acc_q, acc_d;
  frame_t            res_q, res_d;
  logic              res_st_q, res_st_d;
  frame_t            m_data_q, m_data_d;
  logic              m_st_q, m_st_d;

  // Effective capacity, clamped to 1 .. LOOP_DEPTH.
  logic [CNT_W-1:0]  cap;
  logic [CNT_W-1:0]  cap_last;

  // Mode request evaluation.
  logic [MODE_W-1:0] rq_req;
  logic [MODE_W-1:0] rq_mode;
  logic [CNT_W-1:0]  rq_pos;
  logic              rq_first;
  logic              rq_rej;

  // RAM ports.
  logic [ADDR_W-1:0] ram_addr;
  logic              walking;
  logic              take_we, layer_we;
  frame_t            take_wdata, layer_wdata;
  logic [2*SAMPLE_W-1:0] take_rdata_raw, layer_rdata_raw;
  frame_t            take_rd, layer_rd;

  // Shared adder.
  acc_pair_t         add_a, add_b, add_sum;
  frame_t            add_sat;

  // Finish handling.
  logic              fin;
  frame_t            fin_data;
  logic              fin_st;
  logic              out_free;

  logic [CNT_W-1:0]  pos_eff;
  logic [CNT_W-1:0]  pos_inc;
  logic [CNT_W-1:0]  len_grow;

  always_comb begin
    if (cap_q == '0) begin
      cap = CNT_W'(1);
    end else if (32'(cap_q) > LOOP_DEPTH) begin
      cap = CNT_W'(LOOP_DEPTH);
    end else begin
      cap = CNT_W'(cap_q);
    end
  end
  assign cap_last = cap - CNT_W'(1);

  // A position beyond the store reads as frame zero; its low bits already address frame zero.
  assign pos_eff = pos_q[ADDR_W] ? '0 : pos_q;
  assign pos_inc = pos_eff + CNT_W'(1);

  // A housekeeping operation first behaves like a stop request.
  assign rq_req = (op_q == OP_MODE) ? req_q : MODE_STOP;

  always_comb begin
    rq_mode  = mode_q;
    rq_pos   = pos_q;
    rq_first = first_q;
    rq_rej   = 1'b0;
    case (rq_req)
      MODE_STOP: begin
        if (mode_q == MODE_STOP) begin
          rq_rej = 1'b1;
        end else begin
          if (len_q != '0) rq_first = 1'b0;
          rq_mode = MODE_STOP;
          rq_pos  = '0;
        end
      end
      MODE_RECORD: begin
        if (mode_q == MODE_RECORD) begin
          rq_rej = 1'b1;
        end else begin
          if (len_q != '0) rq_first = 1'b0;
          rq_mode = MODE_RECORD;
        end
      end
      MODE_PLAY: begin
        if (len_q == '0 || mode_q == MODE_PLAY) begin
          rq_rej = 1'b1;
        end else if (mode_q == MODE_STOP) begin
          if (first_q) begin
            rq_pos = '0;
            rq_rej = 1'b1;
          end else begin
            rq_mode = MODE_PLAY;
          end
        end else begin
          if (first_q) rq_pos = '0;
          rq_first = 1'b0;
          rq_mode  = MODE_PLAY;
        end
      end
      default: begin
        rq_rej = 1'b1;
      end
    endcase
  end

  // Both stores share one address: the walk index during sweeps, the loop position otherwise.
  assign walking  = state_q inside {S_INIT, S_WRD, S_WWR, S_WCLR};
  assign ram_addr = walking ? idx_q[ADDR_W-1:0] : pos_q[ADDR_W-1:0];

  assign take_rd  = frame_t'(take_rdata_raw);
  assign layer_rd = frame_t'(layer_rdata_raw);

  // Operand selection for the shared adder.
  always_comb begin
    add_a = '0;
    add_b = '0;
    case (state_q)
      S_ADD1: begin
        add_a.l = sext_acc(in_q.l);
        add_a.r = sext_acc(in_q.r);
        add_b.l = sext_acc(take_rd.l);
        add_b.r = sext_acc(take_rd.r);
      end
      S_ADD2: begin
        add_a   = acc_q;
        add_b.l = sext_acc(layer_rd.l);
        add_b.r = sext_acc(layer_rd.r);
      end
      S_WWR: begin
        add_a.l = sext_acc(layer_rd.l);
        add_a.r = sext_acc(layer_rd.r);
        add_b.l = sext_acc(take_rd.l);
        add_b.r = sext_acc(take_rd.r);
      end
      default: begin
        add_a = '0;
        add_b = '0;
      end
    endcase
  end

  alr_sat_add u_add (
    .a_i   (add_a),
    .b_i   (add_b),
    .sum_o (add_sum),
    .sat_o (add_sat)
  );

  assign len_grow = (len_q < cap) ? len_q + CNT_W'(1) : len_q;
  assign out_free = !m_valid_q || m_axis_tready;

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    pos_d       = pos_q;
    len_d       = len_q;
    mode_d      = mode_q;
    first_d     = first_q;
    acc_d       = acc_q;
    res_d       = res_q;
    res_st_d    = res_st_q;
    take_we     = 1'b0;
    take_wdata  = '0;
    layer_we    = 1'b0;
    layer_wdata = '0;
    fin         = 1'b0;
    fin_data    = '0;
    fin_st      = 1'b0;

    case (state_q)
      S_INIT: begin
        take_we  = 1'b1;
        layer_we = 1'b1;
        if (idx_q == DEPTH_LAST) begin
          state_d = S_IDLE;
        end else begin
          idx_d = idx_q + CNT_W'(1);
        end
      end
      S_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        case (op_q)
          OP_SAMPLE: begin
            if (mode_q == MODE_STOP) begin
              fin      = 1'b1;
              fin_data = in_q;
            end else if (mode_q == MODE_RECORD && first_q) begin
              // First take: record the frame and let it through.
              take_we    = 1'b1;
              take_wdata = in_q;
              len_d      = len_grow;
              if (len_grow >= cap) first_d = 1'b0;
              pos_d      = (pos_inc >= cap) ? '0 : pos_inc;
              fin        = 1'b1;
              fin_data   = in_q;
            end else begin
              pos_d   = pos_eff;
              state_d = S_ADD1;
            end
          end
          OP_MODE: begin
            mode_d  = rq_mode;
            pos_d   = rq_pos;
            first_d = rq_first;
            fin     = 1'b1;
            fin_st  = rq_rej;
          end
          OP_STORE: begin
            mode_d  = rq_mode;
            pos_d   = rq_pos;
            first_d = rq_first;
            idx_d   = '0;
            state_d = S_WRD;
          end
          OP_CLRT, OP_CLRA: begin
            mode_d  = rq_mode;
            pos_d   = rq_pos;
            first_d = rq_first;
            idx_d   = '0;
            state_d = S_WCLR;
          end
          default: begin
            fin = 1'b1;
          end
        endcase
      end
      S_ADD1: begin
        // Input plus old take; in overdub the saturated sum goes back into the take.
        acc_d = add_sum;
        if (mode_q == MODE_RECORD) begin
          take_we    = 1'b1;
          take_wdata = add_sat;
        end
        state_d = S_ADD2;
      end
      S_ADD2: begin
        fin      = 1'b1;
        fin_data = add_sat;
        pos_d    = (pos_q + CNT_W'(1) >= len_q) ? '0 : pos_q + CNT_W'(1);
      end
      S_WRD: begin
        state_d = S_WWR;
      end
      S_WWR: begin
        layer_we    = 1'b1;
        layer_wdata = add_sat;
        take_we     = 1'b1;
        if (idx_q == cap_last) begin
          fin = 1'b1;
        end else begin
          idx_d   = idx_q + CNT_W'(1);
          state_d = S_WRD;
        end
      end
      S_WCLR: begin
        take_we  = 1'b1;
        layer_we = (op_q == OP_CLRA);
        if (idx_q == cap_last) begin
          if (op_q == OP_CLRA) begin
            first_d = 1'b1;
            pos_d   = '0;
            len_d   = '0;
          end
          fin = 1'b1;
        end else begin
          idx_d = idx_q + CNT_W'(1);
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // A finished result goes straight to the output register when it is free,
    // otherwise it parks until the receiver takes the previous beat.
    if (fin) begin
      if (out_free) begin
        state_d = S_IDLE;
      end else begin
        res_d    = fin_data;
        res_st_d = fin_st;
        state_d  = S_OUT;
      end
    end
  end

  // Output register loading.
  always_comb begin
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    m_st_d    = m_st_q;
    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end
    if (fin && out_free) begin
      m_valid_d = 1'b1;
      m_data_d  = fin_data;
      m_st_d    = fin_st;
    end else if (state_q == S_OUT && out_free) begin
      m_valid_d = 1'b1;
      m_data_d  = res_q;
      m_st_d    = res_st_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_INIT;
      idx_q     <= '0;
      pos_q     <= '0;
      len_q     <= '0;
      mode_q    <= MODE_STOP;
      first_q   <= 1'b1;
      cap_q     <= CAP_RESET;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      pos_q     <= pos_d;
      len_q     <= len_d;
      mode_q    <= mode_d;
      first_q   <= first_d;
      m_valid_q <= m_valid_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && s_axis_tvalid) begin
      op_q   <= s_axis_tuser;
      in_q.l <= s_axis_tdata[SAMPLE_W-1:0];
      in_q.r <= s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W];
      req_q  <= s_axis_tdata[2*SAMPLE_W+MODE_W-1:2*SAMPLE_W];
    end
    acc_q    <= acc_d;
    res_q    <= res_d;
    res_st_q <= res_st_d;
    m_data_q <= m_data_d;
    m_st_q   <= m_st_d;
  end

  alr_ram #(
    .WIDTH (2 * SAMPLE_W),
    .DEPTH (LOOP_DEPTH)
  ) u_take_ram (
    .clk_i   (clk_i),
    .we_i    (take_we),
    .waddr_i (ram_addr),
    .wdata_i (take_wdata),
    .raddr_i (ram_addr),
    .rdata_o (take_rdata_raw)
  );

  alr_ram #(
    .WIDTH (2 * SAMPLE_W),
    .DEPTH (LOOP_DEPTH)
  ) u_layer_ram (
    .clk_i   (clk_i),
    .we_i    (layer_we),
    .waddr_i (ram_addr),
    .wdata_i (layer_wdata),
    .raddr_i (ram_addr),
    .rdata_o (layer_rdata_raw)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = OUT_DATA_W'(m_data_q);
  assign m_axis_tuser  = m_st_q;

endmodule
